/* src/cbcp_pkg.sv */
`timescale 1ns / 1ps
// Package: widths, byte codes, record kinds and shared structs of the channel parser.
package cbcp_pkg;

   // Widths sized for the largest legal configuration (8 channels, 64-byte block)
   localparam int POS_W    = 7;   // byte position, 0 .. block size
   localparam int CHN_W    = 4;   // channel counter, 0 .. channel count
   localparam int CH_IDX_W = 3;   // channel index field
   localparam int LEN_W    = 6;   // tx/rx length and offset fields
   localparam int SKIP_W   = 7;   // tx + rx
   localparam int NEXT_W   = 8;   // position after a frame

   localparam int DEF_CHANNELS    = 5;
   localparam int DEF_BLOCK_BYTES = 64;

   // Command block byte codes
   localparam logic [7:0] BYTE_DISABLE = 8'h00;
   localparam logic [7:0] BYTE_PAD     = 8'hff;
   localparam logic [7:0] BYTE_END     = 8'hfe;
   localparam logic [7:0] BYTE_RESET   = 8'hfd;
   localparam logic [7:0] LEN_MASK     = 8'h3f;

   localparam logic [LEN_W-1:0] RESET_TX = 6'h01;
   localparam logic [LEN_W-1:0] RESET_RX = 6'h03;

   typedef enum logic [1:0] {
      KIND_DISABLED = 2'd0,
      KIND_FRAME    = 2'd1,
      KIND_RESET    = 2'd2,
      KIND_DONE     = 2'd3
   } record_kind_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [CHN_W-1:0]  chan;
      logic [SKIP_W-1:0] skip;
      logic [LEN_W-1:0]  pend_len;
      logic              pend_v;
      logic              active;
   } scan_state_type;

   typedef struct packed {
      logic [CH_IDX_W-1:0] channel_index;
      record_kind_type     record_kind;
      logic [LEN_W-1:0]    frame_offset;
      logic [LEN_W-1:0]    tx_length;
      logic [LEN_W-1:0]    rx_length;
      logic                frame_overrun;
   } record_type;

   // Records caused by one byte: optional head record, a run of disabled
   // channels, optional done record, sent in that order.
   typedef struct packed {
      logic                head_v;
      record_type          head;
      logic [CH_IDX_W-1:0] run_ch;
      logic [CHN_W-1:0]    run_n;
      logic                done_v;
   } burst_type;

   typedef struct packed {
      logic skid_full;
      logic busy;
   } emit_status_type;

endpackage

/* src/cbcp_if.sv */
`timescale 1ns / 1ps
// Interfaces: command byte channel and parser record channel.
interface cbcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ram_byte;
   logic       first_byte;

   modport source (output valid, output ram_byte, output first_byte, input ready);
   modport sink   (input valid, input ram_byte, input first_byte, output ready);
endinterface

interface cbcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] channel_index;
   logic [1:0] record_kind;
   logic [5:0] frame_offset;
   logic [5:0] tx_length;
   logic [5:0] rx_length;
   logic       frame_overrun;
   logic       last_record;

   modport source (output valid, output channel_index, output record_kind,
                   output frame_offset, output tx_length, output rx_length,
                   output frame_overrun, output last_record, input ready);
   modport sink   (input valid, input channel_index, input record_kind,
                   input frame_offset, input tx_length, input rx_length,
                   input frame_overrun, input last_record, output ready);
endinterface

/* src/cbcp_decode.sv */
`timescale 1ns / 1ps
// Byte decoder: next scan state and the record burst for one command byte.
module cbcp_decode
   import cbcp_pkg::*;
#(
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  scan_state_type state,
   input  logic [7:0]     ram_byte,
   input  logic           first_byte,
   output scan_state_type state_next,
   output burst_type      burst
);

   scan_state_type    eff;
   scan_state_type    nxt;
   burst_type         bst;
   logic              fin;
   logic [POS_W-1:0]  p1;
   logic [CHN_W-1:0]  chan_inc;
   logic [LEN_W-1:0]  tx;
   logic [LEN_W-1:0]  rx;
   logic [SKIP_W-1:0] len_sum;
   logic [NEXT_W-1:0] next_pos;
   logic              chan_full;
   logic              p1_out;

   function automatic logic [LEN_W-1:0] tx_of_byte(input logic [7:0] b);
      tx_of_byte = LEN_W'(b & LEN_MASK);
   endfunction

   always_comb begin
      eff = state;
      if (first_byte) begin
         eff        = '0;
         eff.active = 1'b1;
      end
      nxt = eff;
      bst = '0;
      fin = 1'b0;

      p1        = eff.pos + 1'b1;
      chan_inc  = eff.chan + 1'b1;
      tx        = eff.pend_len;
      rx        = LEN_W'(ram_byte & LEN_MASK);
      len_sum   = SKIP_W'(tx) + SKIP_W'(rx);
      next_pos  = NEXT_W'(p1) + NEXT_W'(len_sum);
      chan_full = chan_inc >= CHN_W'(CHANNELS);
      p1_out    = p1 >= POS_W'(BLOCK_BYTES);

      if (eff.active) begin
         if (eff.pos >= POS_W'(BLOCK_BYTES)) begin
            fin = 1'b1;
         end else begin
            nxt.pos = p1;
            if (eff.skip != '0) begin
               nxt.skip = eff.skip - 1'b1;
            end else if (eff.pend_v && ram_byte != BYTE_END) begin
               // second frame byte: rx length
               nxt.pend_v = 1'b0;
               if (p1_out) begin
                  fin = 1'b1;
               end else begin
                  bst.head_v                  = 1'b1;
                  bst.head.channel_index      = eff.chan[CH_IDX_W-1:0];
                  bst.head.record_kind        = KIND_FRAME;
                  bst.head.frame_offset       = LEN_W'(eff.pos - 1'b1);
                  bst.head.tx_length          = tx;
                  bst.head.rx_length          = rx;
                  bst.head.frame_overrun      = next_pos > NEXT_W'(BLOCK_BYTES);
                  nxt.chan                    = chan_inc;
                  nxt.skip                    = len_sum;
                  fin = chan_full || (next_pos >= NEXT_W'(BLOCK_BYTES));
               end
            end else begin
               // a dangling frame byte before an end code is dropped
               nxt.pend_v = 1'b0;
               case (ram_byte)
                  BYTE_DISABLE: begin
                     bst.head_v             = 1'b1;
                     bst.head.channel_index = eff.chan[CH_IDX_W-1:0];
                     bst.head.record_kind   = KIND_DISABLED;
                     nxt.chan               = chan_inc;
                     fin                    = chan_full || p1_out;
                  end
                  BYTE_PAD: begin
                     fin = (eff.chan >= CHN_W'(CHANNELS)) || p1_out;
                  end
                  BYTE_END: begin
                     bst.run_ch = eff.chan[CH_IDX_W-1:0];
                     if (eff.chan < CHN_W'(CHANNELS)) begin
                        bst.run_n = CHN_W'(CHANNELS) - eff.chan;
                        nxt.chan  = CHN_W'(CHANNELS);
                     end
                     fin = 1'b1;
                  end
                  BYTE_RESET: begin
                     bst.head_v             = 1'b1;
                     bst.head.channel_index = eff.chan[CH_IDX_W-1:0];
                     bst.head.record_kind   = KIND_RESET;
                     bst.head.tx_length     = RESET_TX;
                     bst.head.rx_length     = RESET_RX;
                     nxt.chan               = chan_inc;
                     fin                    = chan_full || p1_out;
                  end
                  default: begin
                     if (!p1_out) begin
                        nxt.pend_len = tx_of_byte(ram_byte);
                        nxt.pend_v   = 1'b1;
                     end else begin
                        fin = 1'b1;
                     end
                  end
               endcase
            end
         end
      end

      if (fin) begin
         bst.done_v = 1'b1;
         nxt.active = 1'b0;
         nxt.pend_v = 1'b0;
         nxt.skip   = '0;
      end

      state_next = nxt;
      burst      = bst;
   end

endmodule

/* src/cbcp_emit.sv */
`timescale 1ns / 1ps
// Record sequencer: skid slot plus burst register, sends one record per transfer.
module cbcp_emit
   import cbcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  burst_type       in_burst,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output record_type      rsp_rec,
   output logic            rsp_last,
   output emit_status_type status
);

   burst_type        burst_ff, burst_in;
   burst_type        skid_ff;
   logic             skid_full_ff, skid_full_in;
   logic [CHN_W:0]   remaining;
   logic             busy;
   logic             out_free;

   assign remaining = (CHN_W+1)'(burst_ff.head_v) + (CHN_W+1)'(burst_ff.run_n)
                    + (CHN_W+1)'(burst_ff.done_v);
   assign busy      = remaining != '0;
   assign rsp_last  = remaining == (CHN_W+1)'(1);
   assign rsp_valid = busy;
   assign out_free  = !busy || (rsp_ready && rsp_last);

   always_comb begin
      rsp_rec = '0;
      if (burst_ff.head_v) begin
         rsp_rec = burst_ff.head;
      end else if (burst_ff.run_n != '0) begin
         rsp_rec.channel_index = burst_ff.run_ch;
         rsp_rec.record_kind   = KIND_DISABLED;
      end else begin
         rsp_rec.record_kind   = KIND_DONE;
      end
   end

   always_comb begin
      burst_in     = burst_ff;
      skid_full_in = skid_full_ff;
      if (out_free) begin
         if (skid_full_ff) begin
            burst_in     = skid_ff;
            skid_full_in = 1'b0;
         end else if (in_valid) begin
            burst_in = in_burst;
         end else begin
            burst_in = '0;
         end
      end else begin
         if (in_valid) begin
            skid_full_in = 1'b1;
         end
         if (rsp_ready) begin
            if (burst_ff.head_v) begin
               burst_in.head_v = 1'b0;
            end else if (burst_ff.run_n != '0) begin
               burst_in.run_n  = burst_ff.run_n - 1'b1;
               burst_in.run_ch = burst_ff.run_ch + 1'b1;
            end else begin
               burst_in.done_v = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff     <= '0;
         skid_full_ff <= 1'b0;
      end else begin
         burst_ff     <= burst_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !out_free) begin
         skid_ff <= in_burst;
      end
   end

   // skid_full in the upper bit, busy in the lower
   assign status = {skid_full_ff, busy};

endmodule

/* src/command_block_channel_parser_unit.sv */
`timescale 1ns / 1ps
// Top level: command block channel parser.
//
//  channel   role    payload                                          transfer when
//  req_chan  sink    ram_byte[7:0], first_byte                        valid && ready
//  rsp_chan  source  channel_index, record_kind, frame_offset,        valid && ready
//                    tx_length, rx_length, frame_overrun, last_record
//
// One command byte is taken per cycle while req ready is high; decode and scan
// state update happen in the cycle of the transfer, and its records go to the
// burst register, or to the skid slot while the sequencer is busy. A byte causes
// up to CHANNELS + 1 records (on an end code), sent one per transfer; bytes
// causing none never occupy the record port. One burst can wait in the skid slot;
// req ready drops only while that slot is full. Reset leaves the scan idle.
module command_block_channel_parser_unit
   import cbcp_pkg::*;
#(
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input logic       clock,
   input logic       reset,
   cbcp_req_if.sink   req_chan,
   cbcp_rsp_if.source rsp_chan
);

   scan_state_type  state_ff, state_in;
   burst_type       burst;
   record_type      rec;
   emit_status_type emit_status;
   logic            req_accept;
   logic            burst_valid;

   // decode sees the live byte and the stored scan state
   cbcp_decode #(
      .CHANNELS    (CHANNELS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_decode (
      .state      (state_ff),
      .ram_byte   (req_chan.ram_byte),
      .first_byte (req_chan.first_byte),
      .state_next (state_in),
      .burst      (burst)
   );

   assign req_chan.ready = !emit_status.skid_full;
   assign req_accept     = req_chan.valid && req_chan.ready;
   // bytes that give no record never occupy the sequencer
   assign burst_valid    = req_accept &&
                           (burst.head_v || burst.run_n != '0 || burst.done_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   cbcp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (burst_valid),
      .in_burst  (burst),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_rec   (rec),
      .rsp_last  (rsp_chan.last_record),
      .status    (emit_status)
   );

   assign rsp_chan.channel_index = rec.channel_index;
   assign rsp_chan.record_kind   = rec.record_kind;
   assign rsp_chan.frame_offset  = rec.frame_offset;
   assign rsp_chan.tx_length     = rec.tx_length;
   assign rsp_chan.rx_length     = rec.rx_length;
   assign rsp_chan.frame_overrun = rec.frame_overrun;

   // a waiting burst implies one is being sent
   a_skid_behind_busy: assert property (@(posedge clock) disable iff (reset)
      emit_status.skid_full |-> (rsp_chan.valid && emit_status.busy))
      else $error("skid slot full while record port idle");

   // a running scan always has a channel left to assign
   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.chan < CHN_W'(CHANNELS)))
      else $error("scan active with no channel left");

   // a frame being skipped ends inside the block
   a_skip_in_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff.active && state_ff.skip != '0) |->
         ((NEXT_W'(state_ff.pos) + NEXT_W'(state_ff.skip)) < NEXT_W'(BLOCK_BYTES)))
      else $error("skip runs past the block while scan active");

endmodule
